[rtl/huffman_table_encoder_packer_core_macros.svh]
// ----------------------------------------------------------------------------
// Huffman encoder assertion macros
// Shared concurrent assertion forms, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TABLE_ENCODER_PACKER_CORE_MACROS_SVH
`define HUFFMAN_TABLE_ENCODER_PACKER_CORE_MACROS_SVH

`ifndef SYNTH

`define HTE_ASSERT(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define HTE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HTE_ASSERT(name, clk, rst_n, expr, msg)

`define HTE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/hte_pkg.sv]
// ----------------------------------------------------------------------------
// Huffman encoder package
// Command codes, fixed field widths and the stage control type.
// ----------------------------------------------------------------------------
package hte_pkg;

    localparam int CMD_W       = 2;
    localparam int SYM_W       = 8;
    localparam int CODE_W      = 32;
    localparam int LEN_W       = 6;
    localparam int BYTE_W      = 8;
    localparam int BYTE_SH     = 3;
    localparam int PEND_W      = 7;
    localparam int PCNT_W      = 3;
    localparam int TABLE_DEPTH = 256;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic vld;
        cmd_t cmd;
    } stage_t;

endpackage

[rtl/hte_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module hte_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             re,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/hte_table.sv]
// ----------------------------------------------------------------------------
// Huffman code table and lookup stage
// Stores code words and lengths, tracks loaded entries and holds the
// looked-up entry of the current transaction for the packer.
// ----------------------------------------------------------------------------
module hte_table #(
    parameter int MAX_CODE_LEN = 32,
    localparam int WORD_W = (MAX_CODE_LEN < hte_pkg::CODE_W) ? MAX_CODE_LEN : hte_pkg::CODE_W,
    localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_take,
    input  logic [hte_pkg::CMD_W-1:0]   cmd,
    input  logic [hte_pkg::SYM_W-1:0]   symbol,
    input  logic [hte_pkg::CODE_W-1:0]  code_bits,
    input  logic [hte_pkg::LEN_W-1:0]   code_len,
    input  logic                        b_take,
    output hte_pkg::stage_t             b_ctl,
    output logic [WORD_W-1:0]           b_word,
    output logic [LEN_W-1:0]            b_len
);

    localparam int ENT_W = WORD_W + LEN_W;

    hte_pkg::stage_t                  stg_reg;
    hte_pkg::stage_t                  stg_next;
    logic [hte_pkg::TABLE_DEPTH-1:0]  loaded_reg;
    logic [hte_pkg::TABLE_DEPTH-1:0]  loaded_next;
    logic                             hit_reg;
    logic                             wr_en;
    logic [LEN_W-1:0]                 len_clamp;
    logic [hte_pkg::CODE_W-1:0]       word_mask;
    logic [ENT_W-1:0]                 wr_entry;
    logic [ENT_W-1:0]                 rd_entry;

    always_comb
    begin
        wr_en = in_take && (hte_pkg::cmd_t'(cmd) == hte_pkg::CMD_LOAD);
        if (code_len > hte_pkg::LEN_W'(MAX_CODE_LEN))
        begin
            len_clamp = LEN_W'(MAX_CODE_LEN);
        end
        else
        begin
            len_clamp = LEN_W'(code_len);
        end
        word_mask = ~({hte_pkg::CODE_W{1'b1}} << len_clamp);
        wr_entry  = {WORD_W'(code_bits & word_mask), len_clamp};
    end

    hte_ram #(
        .WIDTH (ENT_W),
        .DEPTH (hte_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (wr_en),
        .wr_addr (symbol),
        .wr_data (wr_entry),
        .re      (in_take),
        .rd_addr (symbol),
        .rd_data (rd_entry)
    );

    always_comb
    begin
        loaded_next = loaded_reg;
        if (wr_en)
        begin
            loaded_next[symbol] = 1'b1;
        end
        stg_next = stg_reg;
        if (in_take)
        begin
            stg_next.vld = 1'b1;
            stg_next.cmd = hte_pkg::cmd_t'(cmd);
        end
        else if (b_take)
        begin
            stg_next.vld = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_reg    <= '0;
            loaded_reg <= '0;
        end
        else
        begin
            stg_reg    <= stg_next;
            loaded_reg <= loaded_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            hit_reg <= loaded_reg[symbol];
        end
    end

    assign b_ctl  = stg_reg;
    assign b_word = hit_reg ? rd_entry[ENT_W-1:LEN_W] : '0;
    assign b_len  = hit_reg ? rd_entry[LEN_W-1:0] : '0;

endmodule

[rtl/hte_packer.sv]
// ----------------------------------------------------------------------------
// Huffman bit packer and byte emitter
// Appends code words to the pending bits, left-aligns the completed bytes
// into the emit register and sends them one byte per output transaction.
// ----------------------------------------------------------------------------
`include "huffman_table_encoder_packer_core_macros.svh"

module hte_packer #(
    parameter int MAX_CODE_LEN = 32,
    localparam int WORD_W = (MAX_CODE_LEN < hte_pkg::CODE_W) ? MAX_CODE_LEN : hte_pkg::CODE_W,
    localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hte_pkg::stage_t             b_ctl,
    input  logic [WORD_W-1:0]           b_word,
    input  logic [LEN_W-1:0]            b_len,
    output logic                        b_take,
    output logic [hte_pkg::BYTE_W-1:0]  out_byte,
    output logic                        last,
    output logic                        out_valid,
    input  logic                        out_ready
);

    localparam int ACC_W  = hte_pkg::PEND_W + MAX_CODE_LEN;
    localparam int NB_MAX = ACC_W / hte_pkg::BYTE_W;
    localparam int LA_W   = hte_pkg::BYTE_W * ((ACC_W + hte_pkg::BYTE_W - 1) / hte_pkg::BYTE_W);
    localparam int TOT_W  = $clog2(ACC_W + 1);
    localparam int NB_W   = $clog2(NB_MAX + 1);
    localparam int SH_W   = $clog2(LA_W + 1);

    logic [hte_pkg::PEND_W-1:0] pend_bits_reg;
    logic [hte_pkg::PEND_W-1:0] pend_bits_next;
    logic [hte_pkg::PCNT_W-1:0] pend_cnt_reg;
    logic [hte_pkg::PCNT_W-1:0] pend_cnt_next;
    logic [NB_W-1:0]            cnt_reg;
    logic [NB_W-1:0]            cnt_next;
    logic [LA_W-1:0]            bytes_reg;
    logic [LA_W-1:0]            bytes_next;
    logic [ACC_W-1:0]           acc;
    logic [TOT_W-1:0]           total;
    logic [ACC_W-1:0]           src;
    logic [TOT_W-1:0]           tot;
    logic [NB_W-1:0]            nb;
    logic [LA_W-1:0]            la;
    logic                       upd;
    logic                       emit_free;
    logic                       out_fire;

    always_comb
    begin
        acc   = (ACC_W'(pend_bits_reg) << b_len) | ACC_W'(b_word);
        total = TOT_W'(pend_cnt_reg) + TOT_W'(b_len);
        case (b_ctl.cmd)
            hte_pkg::CMD_ENCODE:
            begin
                src            = acc;
                tot            = total;
                nb             = NB_W'(total >> hte_pkg::BYTE_SH);
                pend_bits_next = hte_pkg::PEND_W'(acc)
                                 & ~({hte_pkg::PEND_W{1'b1}} << total[hte_pkg::BYTE_SH-1:0]);
                pend_cnt_next  = total[hte_pkg::BYTE_SH-1:0];
                upd            = 1'b1;
            end
            hte_pkg::CMD_FLUSH:
            begin
                src            = ACC_W'(pend_bits_reg);
                tot            = TOT_W'(pend_cnt_reg);
                nb             = (pend_cnt_reg != '0) ? NB_W'(1) : '0;
                pend_bits_next = '0;
                pend_cnt_next  = '0;
                upd            = 1'b1;
            end
            default:
            begin
                src            = acc;
                tot            = total;
                nb             = '0;
                pend_bits_next = pend_bits_reg;
                pend_cnt_next  = pend_cnt_reg;
                upd            = 1'b0;
            end
        endcase
        la = LA_W'(src) << (SH_W'(LA_W) - SH_W'(tot));
    end

    always_comb
    begin
        out_valid = (cnt_reg != '0);
        out_fire  = out_valid && out_ready;
        emit_free = (cnt_reg == '0) || ((cnt_reg == NB_W'(1)) && out_ready);
        b_take    = b_ctl.vld && ((nb == '0) || emit_free);
        cnt_next   = cnt_reg;
        bytes_next = bytes_reg;
        if (b_take && (nb != '0))
        begin
            cnt_next   = nb;
            bytes_next = la;
        end
        else if (out_fire)
        begin
            cnt_next   = cnt_reg - NB_W'(1);
            bytes_next = bytes_reg << hte_pkg::BYTE_W;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (b_take && upd)
            begin
                pend_bits_reg <= pend_bits_next;
                pend_cnt_reg  <= pend_cnt_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

    assign out_byte = bytes_reg[LA_W-1 -: hte_pkg::BYTE_W];
    assign last     = (cnt_reg == NB_W'(1));

    `HTE_ASSERT(a_cnt_range, clk, rst_n, cnt_reg <= NB_W'(NB_MAX), "Emit byte count is out of range.")
    `HTE_ASSERT(a_pend_clean, clk, rst_n, (pend_bits_reg >> pend_cnt_reg) == '0, "Stale bits above the pending count.")
    `HTE_ASSERT_NEXT(a_drain, clk, rst_n, out_fire && (cnt_reg > NB_W'(1)), cnt_reg == ($past(cnt_reg) - NB_W'(1)), "Byte count did not step down after a transaction.")
    `HTE_ASSERT_NEXT(a_flush, clk, rst_n, b_take && (b_ctl.cmd == hte_pkg::CMD_FLUSH) && (pend_cnt_reg != '0), (cnt_reg == NB_W'(1)) && (pend_cnt_reg == '0), "Flush did not emit one byte and clear the pending bits.")

endmodule

[rtl/huffman_table_encoder_packer_core.sv]
// ----------------------------------------------------------------------------
// Huffman table encoder and packer
// An item is registered in the table stage, then in the emit register once free.
// Throughput: one item per cycle while each gives at most one byte and out_ready
// is high; an item completing N bytes (N up to 4) holds the one-byte output port
// until all N are taken. Reset: asynchronous, active low; the 256 entry-loaded
// flags clear at once (no clearing pass); items are accepted in the first cycle.
// ----------------------------------------------------------------------------
module huffman_table_encoder_packer_core #(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [hte_pkg::CMD_W-1:0]   cmd,
    input  logic [hte_pkg::SYM_W-1:0]   symbol,
    input  logic [hte_pkg::CODE_W-1:0]  code_bits,
    input  logic [hte_pkg::LEN_W-1:0]   code_len,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [hte_pkg::BYTE_W-1:0]  out_byte,
    output logic                        last
);

    localparam int WORD_W = (MAX_CODE_LEN < hte_pkg::CODE_W) ? MAX_CODE_LEN : hte_pkg::CODE_W;
    localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);

    hte_pkg::stage_t   b_ctl;
    logic [WORD_W-1:0] b_word;
    logic [LEN_W-1:0]  b_len;
    logic              b_take;
    logic              in_take;

    assign in_ready = !b_ctl.vld || b_take;
    assign in_take  = in_valid && in_ready;

    hte_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (in_take),
        .cmd       (cmd),
        .symbol    (symbol),
        .code_bits (code_bits),
        .code_len  (code_len),
        .b_take    (b_take),
        .b_ctl     (b_ctl),
        .b_word    (b_word),
        .b_len     (b_len)
    );

    hte_packer #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .b_ctl     (b_ctl),
        .b_word    (b_word),
        .b_len     (b_len),
        .b_take    (b_take),
        .out_byte  (out_byte),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule
